[rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nms assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define NMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nms assertion failed");

`endif

[rtl/nms_pkg.sv]
// shared types, codes and arithmetic helpers of the simplex engine
package nms_pkg;

  localparam int NDIM  = 2;
  localparam int NVERT = NDIM + 1;
  localparam int MDEPTH = NVERT * NDIM;
  localparam int AW    = $clog2(MDEPTH);

  typedef logic signed [31:0] q16_t;
  typedef logic signed [34:0] wide_t;

  // item actions
  localparam logic [2:0] ACT_COORD = 3'd0;
  localparam logic [2:0] ACT_VALUE = 3'd1;
  localparam logic [2:0] ACT_BOUND = 3'd2;
  localparam logic [2:0] ACT_START = 3'd3;
  localparam logic [2:0] ACT_EVAL  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_TOL   = 2'd0;
  localparam logic [1:0] REG_MAXE  = 2'd1;
  localparam logic [1:0] REG_BOUND = 2'd2;

  // store address of coordinate c of physical slot s
  function automatic logic [AW-1:0] maddr(input logic [1:0] s, input logic c);
    return AW'(int'(s) * NDIM + int'(c));
  endfunction

  function automatic wide_t ext35(input q16_t a);
    return {{3{a[31]}}, a};
  endfunction

  // saturate to the q16.16 range
  function automatic q16_t sat35(input wide_t x);
    q16_t r;
    if (x > ext35(32'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    else if (x < ext35(32'sh8000_0000)) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // |a - b| saturated to 31 bits
  function automatic logic [30:0] absd(input q16_t a, input q16_t b);
    logic signed [32:0] d;
    logic [32:0] m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 33'(-d) : 33'(d);
    return (m > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
  endfunction

  // floor of the mean of two values
  function automatic q16_t half(input q16_t a, input q16_t b);
    logic signed [32:0] s;
    s = ($signed({a[31], a}) + $signed({b[31], b})) >>> 1;
    return s[31:0];
  endfunction

  // clip to low then high bound when en is set
  function automatic q16_t clip(input q16_t x, input q16_t lo, input q16_t hi,
                                input logic en);
    q16_t r;
    r = x;
    if (en) begin
      if (r < lo) r = lo;
      if (r > hi) r = hi;
    end
    return r;
  endfunction

endpackage

[rtl/nms_ifs.sv]
// item channels of the simplex engine
interface nms_in_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               action;
  logic [1:0]               vertex_index;
  logic                     coord_index;
  logic signed [31:0]       coord_value;
  logic signed [31:0]       fvalue;
  logic signed [31:0]       bound_low;
  logic signed [31:0]       bound_high;
  modport source (output valid, action, vertex_index, coord_index, coord_value,
                  fvalue, bound_low, bound_high, input ready);
  modport sink (input valid, action, vertex_index, coord_index, coord_value,
                fvalue, bound_low, bound_high, output ready);
endinterface

interface nms_out_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [1:0]               out_vertex;
  logic                     out_coord_index;
  logic signed [31:0]       out_coord;
  logic signed [31:0]       vertex_value;
  logic                     last;
  logic [15:0]              eval_count;
  logic                     stop_reason;
  modport source (output valid, kind, out_vertex, out_coord_index, out_coord,
                  vertex_value, last, eval_count, stop_reason, input ready);
  modport sink (input valid, kind, out_vertex, out_coord_index, out_coord,
                vertex_value, last, eval_count, stop_reason, output ready);
endinterface

[rtl/nelder_mead_simplex_engine.sv]
// top level of the nelder-mead simplex controller
// Usage: in_ch carries load, start and evaluation items; out_ch carries
// trial-point coordinates (kind 0, last on the final coordinate) and, at
// the stop, the sorted simplex (kind 1) with count and stop reason.
// Objective evaluation happens outside: after each requested point the
// host returns one evaluation item. Registers sit on the apb port.
// Rate: one item at a time. Loads are stored as they are taken. After a start,
// and after a returned value that replaces the worst vertex (the new point is
// written first, one coordinate a cycle), the first result follows the 3
// compare-exchange steps of the sort, the sweep through the vertex store (a
// read and an accumulate step per coordinate; single read port, registered
// read) and a decision step; then one result a cycle while out_ch accepts.
// A returned value that asks for an expansion or contraction point gives its
// results straight after its evaluation step. Shrink: two reads, one write
// per coordinate. The final simplex takes a read and an output per result.
// Reset (synchronous, rst_n low) returns to idle, clears the count and the
// registers to their defaults; vertex and bound contents are kept.
// A stalled out_ch holds the result in the output register and the
// sequencer waits; in_ch.ready is low while the sequencer is busy.
`include "assert_macros.svh"

module nelder_mead_simplex_engine (
  input  logic         clk,
  input  logic         rst_n,
  nms_in_if.sink       in_ch,
  nms_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int NDIM  = nms_pkg::NDIM;
  localparam int NVERT = nms_pkg::NVERT;
  localparam int AW    = nms_pkg::AW;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SORT0 = 4'd1;
  localparam logic [3:0] S_SORT1 = 4'd2;
  localparam logic [3:0] S_SORT2 = 4'd3;
  localparam logic [3:0] S_PRD   = 4'd4;
  localparam logic [3:0] S_PACC  = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FOUT  = 4'd9;
  localparam logic [3:0] S_EVAL  = 4'd10;
  localparam logic [3:0] S_WR    = 4'd11;
  localparam logic [3:0] S_SHB   = 4'd12;
  localparam logic [3:0] S_SHV   = 4'd13;
  localparam logic [3:0] S_SHC   = 4'd14;

  // run phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_REFLECT = 3'd1;
  localparam logic [2:0] PH_EXPAND  = 3'd2;
  localparam logic [2:0] PH_OUTSIDE = 3'd3;
  localparam logic [2:0] PH_INSIDE  = 3'd4;
  localparam logic [2:0] PH_SHRINK  = 3'd5;

  // configuration
  logic [30:0] tol_r;
  logic [15:0] maxe_r;
  logic        ben_r;

  // control
  logic [3:0]  seq_r, seq_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  r_r, r_nxt;
  logic        c_r, c_nxt;
  logic [1:0]  sv_r, sv_nxt;
  logic [15:0] evals_r, evals_nxt;
  logic        stop_r, stop_nxt;
  logic [1:0]  perm_r [NVERT];
  logic [1:0]  perm_nxt [NVERT];

  // working data
  nms_pkg::q16_t val_r [NVERT];
  nms_pkg::q16_t val_nxt [NVERT];
  nms_pkg::q16_t cen_r [NDIM];
  nms_pkg::q16_t cen_nxt [NDIM];
  nms_pkg::q16_t wst_r [NDIM];
  nms_pkg::q16_t wst_nxt [NDIM];
  nms_pkg::q16_t refl_r [NDIM];
  nms_pkg::q16_t refl_nxt [NDIM];
  nms_pkg::q16_t pt_r [NDIM];
  nms_pkg::q16_t pt_nxt [NDIM];
  nms_pkg::q16_t lo_r [NDIM];
  nms_pkg::q16_t lo_nxt [NDIM];
  nms_pkg::q16_t hi_r [NDIM];
  nms_pkg::q16_t hi_nxt [NDIM];
  nms_pkg::q16_t rv_r, rv_nxt;
  nms_pkg::q16_t f_r, f_nxt;
  nms_pkg::q16_t base_r, base_nxt;
  nms_pkg::wide_t sum_r, sum_nxt;
  logic [30:0] xs_r, xs_nxt;

  // vertex store
  nms_pkg::q16_t mem [nms_pkg::MDEPTH];
  nms_pkg::q16_t rd_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  nms_pkg::q16_t mem_wd;

  // output register
  logic          out_valid_r;
  logic          o_kind_r, o_kind;
  logic [1:0]    o_vert_r, o_vert;
  logic          o_ci_r, o_ci;
  nms_pkg::q16_t o_coord_r, o_coord;
  nms_pkg::q16_t o_val_r, o_val;
  logic          o_last_r, o_last;
  logic [15:0]   o_cnt_r;
  logic          o_stop_r, o_stop;
  logic          ld_out;

  logic in_acc, out_free, cfg_wr;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (seq_r == S_IDLE);

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      nms_pkg::REG_TOL:   prdata = {1'b0, tol_r};
      nms_pkg::REG_MAXE:  prdata = {16'd0, maxe_r};
      nms_pkg::REG_BOUND: prdata = {31'd0, ben_r};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= 31'd66;
      maxe_r <= 16'd1000;
      ben_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        nms_pkg::REG_TOL:   tol_r  <= pwdata[30:0];
        nms_pkg::REG_MAXE:  maxe_r <= pwdata[15:0];
        nms_pkg::REG_BOUND: ben_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // vertex store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[mem_ra];
  end

  // sequencer next state and datapath
  always_comb begin
    logic [30:0]    fs;
    logic [30:0]    d;
    nms_pkg::wide_t s2;
    nms_pkg::wide_t t35;
    nms_pkg::q16_t  t;
    logic [1:0]     ptmp;
    nms_pkg::q16_t  vtmp;

    seq_nxt = seq_r;   phase_nxt = phase_r; r_nxt = r_r; c_nxt = c_r;
    sv_nxt = sv_r;     evals_nxt = evals_r; stop_nxt = stop_r;
    perm_nxt = perm_r; val_nxt = val_r;     cen_nxt = cen_r; wst_nxt = wst_r;
    refl_nxt = refl_r; pt_nxt = pt_r;       lo_nxt = lo_r;   hi_nxt = hi_r;
    rv_nxt = rv_r;     f_nxt = f_r;         base_nxt = base_r;
    sum_nxt = sum_r;   xs_nxt = xs_r;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_re = 1'b0; mem_ra = '0;
    ld_out = 1'b0; o_kind = 1'b0; o_vert = 2'd0; o_ci = 1'b0; o_coord = '0;
    o_val = '0; o_last = 1'b0; o_stop = 1'b0;
    fs = '0; d = '0; s2 = '0; t35 = '0; t = '0; ptmp = '0; vtmp = '0;

    case (seq_r)
      // take items
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.action)
            nms_pkg::ACT_COORD: begin
              if (int'(in_ch.vertex_index) <= NDIM && int'(in_ch.coord_index) < NDIM) begin
                mem_we = 1'b1;
                mem_wa = nms_pkg::maddr(perm_r[in_ch.vertex_index], in_ch.coord_index);
                mem_wd = in_ch.coord_value;
                if (int'(in_ch.vertex_index) == NDIM)
                  wst_nxt[in_ch.coord_index] = in_ch.coord_value;
              end
            end
            nms_pkg::ACT_VALUE: begin
              if (int'(in_ch.vertex_index) <= NDIM)
                val_nxt[in_ch.vertex_index] = in_ch.fvalue;
            end
            nms_pkg::ACT_BOUND: begin
              if (int'(in_ch.coord_index) < NDIM) begin
                lo_nxt[in_ch.coord_index] = in_ch.bound_low;
                hi_nxt[in_ch.coord_index] = in_ch.bound_high;
              end
            end
            nms_pkg::ACT_START: begin
              evals_nxt = 16'(NVERT);
              seq_nxt = S_SORT0;
            end
            nms_pkg::ACT_EVAL: begin
              if (phase_r != PH_IDLE) begin
                if (evals_r != 16'hFFFF) evals_nxt = evals_r + 16'd1;
                f_nxt = in_ch.fvalue;
                seq_nxt = S_EVAL;
              end
            end
            default: ;
          endcase
        end
      end

      // stable sort by value, ranks hold physical slots
      S_SORT0, S_SORT2: begin
        if (val_r[0] > val_r[1]) begin
          val_nxt[0] = val_r[1]; val_nxt[1] = val_r[0];
          perm_nxt[0] = perm_r[1]; perm_nxt[1] = perm_r[0];
        end
        if (seq_r == S_SORT0) begin
          seq_nxt = S_SORT1;
        end else begin
          r_nxt = 2'd0; c_nxt = 1'b0; xs_nxt = '0;
          seq_nxt = S_PRD;
        end
      end
      S_SORT1: begin
        if (val_r[1] > val_r[2]) begin
          val_nxt[1] = val_r[2]; val_nxt[2] = val_r[1];
          perm_nxt[1] = perm_r[2]; perm_nxt[2] = perm_r[1];
        end
        seq_nxt = S_SORT2;
      end

      // sweep: x-spread, centroid and worst vertex per coordinate
      S_PRD: begin
        mem_re = 1'b1;
        mem_ra = nms_pkg::maddr(perm_r[r_r], c_r);
        seq_nxt = S_PACC;
      end
      S_PACC: begin
        if (r_r == 2'd0) begin
          base_nxt = rd_r;
          sum_nxt = nms_pkg::ext35(rd_r);
        end else begin
          d = nms_pkg::absd(rd_r, base_r);
          if (d > xs_r) xs_nxt = d;
          if (int'(r_r) < NDIM) sum_nxt = sum_r + nms_pkg::ext35(rd_r);
        end
        if (int'(r_r) == NDIM) begin
          wst_nxt[c_r] = rd_r;
          s2 = sum_r >>> 1;
          cen_nxt[c_r] = s2[31:0];
          r_nxt = 2'd0;
          if (int'(c_r) == NDIM - 1) begin
            seq_nxt = S_DEC;
          end else begin
            c_nxt = c_r + 1'b1;
            seq_nxt = S_PRD;
          end
        end else begin
          r_nxt = r_r + 2'd1;
          seq_nxt = S_PRD;
        end
      end

      // stop test, else reflect
      S_DEC: begin
        for (int i = 1; i < NVERT; i++) begin
          if (nms_pkg::absd(val_r[i], val_r[0]) > fs) fs = nms_pkg::absd(val_r[i], val_r[0]);
        end
        r_nxt = 2'd0; c_nxt = 1'b0;
        if (fs <= tol_r && xs_r <= tol_r) begin
          stop_nxt = 1'b0; phase_nxt = PH_IDLE; seq_nxt = S_FRD;
        end else if (evals_r >= maxe_r) begin
          stop_nxt = 1'b1; phase_nxt = PH_IDLE; seq_nxt = S_FRD;
        end else begin
          for (int k = 0; k < NDIM; k++) begin
            t = nms_pkg::clip(nms_pkg::sat35((nms_pkg::ext35(cen_r[k]) <<< 1)
                  - nms_pkg::ext35(wst_r[k])), lo_r[k], hi_r[k], ben_r);
            refl_nxt[k] = t;
            pt_nxt[k] = t;
          end
          phase_nxt = PH_REFLECT;
          seq_nxt = S_EMIT;
        end
      end

      // request a point, one coordinate a cycle while out_ch accepts
      S_EMIT: begin
        if (out_free) begin
          ld_out = 1'b1;
          o_ci = c_r; o_coord = pt_r[c_r]; o_last = (int'(c_r) == NDIM - 1);
          if (int'(c_r) == NDIM - 1) begin
            c_nxt = 1'b0; seq_nxt = S_IDLE;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end

      // final simplex
      S_FRD: begin
        mem_re = 1'b1;
        mem_ra = nms_pkg::maddr(perm_r[r_r], c_r);
        seq_nxt = S_FOUT;
      end
      S_FOUT: begin
        if (out_free) begin
          ld_out = 1'b1;
          o_kind = 1'b1; o_vert = r_r; o_ci = c_r; o_coord = rd_r; o_val = val_r[r_r];
          o_last = (int'(r_r) == NDIM) && (int'(c_r) == NDIM - 1);
          o_stop = stop_r;
          seq_nxt = S_FRD;
          if (int'(c_r) == NDIM - 1) begin
            c_nxt = 1'b0;
            if (int'(r_r) == NDIM) seq_nxt = S_IDLE;
            else r_nxt = r_r + 2'd1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end

      // act on a returned value
      S_EVAL: begin
        c_nxt = 1'b0;
        case (phase_r)
          PH_REFLECT: begin
            rv_nxt = f_r;
            if (f_r < val_r[0]) begin
              for (int k = 0; k < NDIM; k++) begin
                t35 = nms_pkg::ext35(cen_r[k]) + (nms_pkg::ext35(cen_r[k]) <<< 1)
                      - (nms_pkg::ext35(wst_r[k]) <<< 1);
                pt_nxt[k] = nms_pkg::clip(nms_pkg::sat35(t35), lo_r[k], hi_r[k], ben_r);
              end
              phase_nxt = PH_EXPAND; seq_nxt = S_EMIT;
            end else if (f_r < val_r[NDIM-1]) begin
              pt_nxt = refl_r; val_nxt[NDIM] = f_r; seq_nxt = S_WR;
            end else if (f_r < val_r[NDIM]) begin
              for (int k = 0; k < NDIM; k++) begin
                t35 = (nms_pkg::ext35(cen_r[k]) + (nms_pkg::ext35(cen_r[k]) <<< 1)
                      - nms_pkg::ext35(wst_r[k])) >>> 1;
                pt_nxt[k] = nms_pkg::clip(nms_pkg::sat35(t35), lo_r[k], hi_r[k], ben_r);
              end
              phase_nxt = PH_OUTSIDE; seq_nxt = S_EMIT;
            end else begin
              for (int k = 0; k < NDIM; k++)
                pt_nxt[k] = nms_pkg::clip(nms_pkg::half(cen_r[k], wst_r[k]),
                                          lo_r[k], hi_r[k], ben_r);
              phase_nxt = PH_INSIDE; seq_nxt = S_EMIT;
            end
          end
          PH_EXPAND: begin
            if (f_r < rv_r) begin
              val_nxt[NDIM] = f_r;
            end else begin
              pt_nxt = refl_r; val_nxt[NDIM] = rv_r;
            end
            seq_nxt = S_WR;
          end
          PH_OUTSIDE, PH_INSIDE: begin
            if ((phase_r == PH_OUTSIDE) ? (f_r <= rv_r) : (f_r < val_r[NDIM])) begin
              val_nxt[NDIM] = f_r; seq_nxt = S_WR;
            end else begin
              sv_nxt = 2'd1; seq_nxt = S_SHB;
            end
          end
          PH_SHRINK: begin
            val_nxt[sv_r] = f_r;
            sv_nxt = sv_r + 2'd1;
            if (int'(sv_r) < NDIM) seq_nxt = S_SHB;
            else seq_nxt = S_SORT0;
          end
          default: seq_nxt = S_IDLE;
        endcase
      end

      // replace worst vertex
      S_WR: begin
        mem_we = 1'b1;
        mem_wa = nms_pkg::maddr(perm_r[NDIM], c_r);
        mem_wd = pt_r[c_r];
        if (int'(c_r) == NDIM - 1) begin
          c_nxt = 1'b0; seq_nxt = S_SORT0;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end

      // shrink one vertex toward the best, read best then vertex
      S_SHB: begin
        mem_re = 1'b1;
        mem_ra = nms_pkg::maddr(perm_r[0], c_r);
        seq_nxt = S_SHV;
      end
      S_SHV: begin
        base_nxt = rd_r;
        mem_re = 1'b1;
        mem_ra = nms_pkg::maddr(perm_r[sv_r], c_r);
        seq_nxt = S_SHC;
      end
      S_SHC: begin
        ptmp = perm_r[sv_r];
        vtmp = nms_pkg::clip(nms_pkg::half(base_r, rd_r), lo_r[c_r], hi_r[c_r], ben_r);
        mem_we = 1'b1;
        mem_wa = nms_pkg::maddr(ptmp, c_r);
        mem_wd = vtmp;
        pt_nxt[c_r] = vtmp;
        if (int'(c_r) == NDIM - 1) begin
          c_nxt = 1'b0; phase_nxt = PH_SHRINK; seq_nxt = S_EMIT;
        end else begin
          c_nxt = c_r + 1'b1; seq_nxt = S_SHB;
        end
      end

      default: seq_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= S_IDLE;
      phase_r <= PH_IDLE;
      r_r <= 2'd0;
      c_r <= 1'b0;
      sv_r <= 2'd0;
      evals_r <= 16'd0;
      stop_r <= 1'b0;
      for (int i = 0; i < NVERT; i++) perm_r[i] <= 2'(i);
    end else begin
      seq_r <= seq_nxt;
      phase_r <= phase_nxt;
      r_r <= r_nxt;
      c_r <= c_nxt;
      sv_r <= sv_nxt;
      evals_r <= evals_nxt;
      stop_r <= stop_nxt;
      perm_r <= perm_nxt;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cen_r <= cen_nxt;
    wst_r <= wst_nxt;
    refl_r <= refl_nxt;
    pt_r <= pt_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    rv_r <= rv_nxt;
    f_r <= f_nxt;
    base_r <= base_nxt;
    sum_r <= sum_nxt;
    xs_r <= xs_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ld_out) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      o_kind_r <= o_kind;
      o_vert_r <= o_vert;
      o_ci_r <= o_ci;
      o_coord_r <= o_coord;
      o_val_r <= o_val;
      o_last_r <= o_last;
      o_cnt_r <= evals_r;
      o_stop_r <= o_stop;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = o_kind_r;
  assign out_ch.out_vertex = o_vert_r;
  assign out_ch.out_coord_index = o_ci_r;
  assign out_ch.out_coord = o_coord_r;
  assign out_ch.vertex_value = o_val_r;
  assign out_ch.last = o_last_r;
  assign out_ch.eval_count = o_cnt_r;
  assign out_ch.stop_reason = o_stop_r;

  // checks
  `NMS_ASSERT_IMP(a_shrink_rank, (phase_r == PH_SHRINK && seq_r == S_IDLE), (sv_r >= 2'd1 && int'(sv_r) <= NDIM))
  `NMS_ASSERT_NXT(a_idle_eval, (in_acc && in_ch.action == nms_pkg::ACT_EVAL && phase_r == PH_IDLE), (seq_r == S_IDLE && evals_r == $past(evals_r)))
  `NMS_ASSERT_NXT(a_count_mono, !(in_acc && in_ch.action == nms_pkg::ACT_START), (evals_r >= $past(evals_r)))
  `NMS_ASSERT_IMP(a_final_idle, (out_valid_r && o_kind_r && o_last_r && seq_r == S_IDLE), (phase_r == PH_IDLE))

endmodule
